// ----- design/fsg_pkg.sv -----
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared types and constants of the falling-sand grid block.
// ----------------------------------------------------------------------------
package fsg_pkg;

    localparam int FSG_GRID_COLS  = 128;
    localparam int FSG_GRID_ROWS  = 128;
    localparam int FSG_NUM_COLORS = 8;

    localparam int OP_W      = 2;
    localparam int POS_W     = 7;
    localparam int COLOR_W   = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PLACE = 2'd0,
        OP_ERASE = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        DIR_SELF  = 3'd0,
        DIR_DOWN  = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_EAST  = 3'd4
    } dir_t;

    typedef struct packed {
        logic               occ;
        logic [COLOR_W-1:0] color;
    } cell_t;

    typedef struct packed {
        op_t                op;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } item_t;

    typedef struct packed {
        logic               placed_ok;
        logic               cell_occupied;
        logic [COLOR_W-1:0] cell_color;
    } result_t;

endpackage

// ----- design/fsg_cell_mem.sv -----
// ----------------------------------------------------------------------------
// fsg_cell_mem
// Cell store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module fsg_cell_mem
    import fsg_pkg::*;
#(
    parameter int GRID_COLS = FSG_GRID_COLS,
    parameter int GRID_ROWS = FSG_GRID_ROWS
)
(
    input  logic                                              clk,
    input  logic                                              wr_en,
    input  logic [$clog2(GRID_COLS)+$clog2(GRID_ROWS)-1:0]    wr_addr,
    input  cell_t                                             wr_data,
    input  logic [$clog2(GRID_COLS)+$clog2(GRID_ROWS)-1:0]    rd_addr,
    output cell_t                                             rd_data
);

    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int DEPTH  = GRID_COLS * (2 ** ROW_W);

    cell_t mem [DEPTH];
    cell_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/fsg_addr_unit.sv -----
// ----------------------------------------------------------------------------
// fsg_addr_unit
// Neighbor address and bounds check, shared by every operation.
// ----------------------------------------------------------------------------
module fsg_addr_unit
    import fsg_pkg::*;
#(
    parameter int GRID_COLS = FSG_GRID_COLS,
    parameter int GRID_ROWS = FSG_GRID_ROWS
)
(
    input  logic [$clog2(GRID_COLS)-1:0]                      x,
    input  logic [$clog2(GRID_ROWS)-1:0]                      y,
    input  dir_t                                              dir,
    output logic [$clog2(GRID_COLS)+$clog2(GRID_ROWS)-1:0]    addr,
    output logic                                              valid
);

    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);

    logic [COL_W:0]   x_inc;
    logic [ROW_W:0]   y_inc;
    logic [COL_W-1:0] x_dec;
    logic [COL_W-1:0] tx;
    logic [ROW_W-1:0] ty;
    logic             down_ok;
    logic             right_ok;
    logic             left_ok;

    assign x_inc    = {1'b0, x} + (COL_W+1)'(1);
    assign y_inc    = {1'b0, y} + (ROW_W+1)'(1);
    assign x_dec    = x - COL_W'(1);
    assign down_ok  = y_inc < (ROW_W+1)'(GRID_ROWS);
    assign right_ok = x_inc < (COL_W+1)'(GRID_COLS);
    assign left_ok  = x != '0;

    always_comb
    begin
        tx    = x;
        ty    = y;
        valid = 1'b0;
        unique case (dir)
            DIR_SELF:
            begin
                valid = 1'b1;
            end
            DIR_DOWN:
            begin
                ty    = y_inc[ROW_W-1:0];
                valid = down_ok;
            end
            DIR_LEFT:
            begin
                tx    = x_dec;
                ty    = y_inc[ROW_W-1:0];
                valid = down_ok && left_ok;
            end
            DIR_RIGHT:
            begin
                tx    = x_inc[COL_W-1:0];
                ty    = y_inc[ROW_W-1:0];
                valid = down_ok && right_ok;
            end
            DIR_EAST:
            begin
                tx    = x_inc[COL_W-1:0];
                valid = right_ok;
            end
            default:
            begin
                valid = 1'b0;
            end
        endcase
    end

    assign addr = {tx, ty};

endmodule

// ----- design/fsg_seq.sv -----
// ----------------------------------------------------------------------------
// fsg_seq
// Operation sequencer: clearing pass, place, erase, read and the tick sweep.
// ----------------------------------------------------------------------------
module fsg_seq
    import fsg_pkg::*;
#(
    parameter int GRID_COLS  = FSG_GRID_COLS,
    parameter int GRID_ROWS  = FSG_GRID_ROWS,
    parameter int NUM_COLORS = FSG_NUM_COLORS
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  item_t                                             item,
    output logic                                              ready,
    output logic                                              res_valid,
    input  logic                                              res_take,
    output result_t                                           res,
    output logic [$clog2(GRID_COLS)-1:0]                      unit_x,
    output logic [$clog2(GRID_ROWS)-1:0]                      unit_y,
    output dir_t                                              unit_dir,
    input  logic [$clog2(GRID_COLS)+$clog2(GRID_ROWS)-1:0]    unit_addr,
    input  logic                                              unit_valid,
    output logic                                              wr_en,
    output logic [$clog2(GRID_COLS)+$clog2(GRID_ROWS)-1:0]    wr_addr,
    output cell_t                                             wr_data,
    output logic [$clog2(GRID_COLS)+$clog2(GRID_ROWS)-1:0]    rd_addr,
    input  cell_t                                             rd_data
);

    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = GRID_COLS * (2 ** ROW_W);

    localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(GRID_COLS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(GRID_ROWS - 1);
    localparam logic [COLOR_W-1:0] COLOR_TOP = COLOR_W'(NUM_COLORS - 1);

    typedef enum logic [14:0] {
        ST_CLEAR    = 15'b000000000000001,
        ST_IDLE     = 15'b000000000000010,
        ST_PLACE_RD = 15'b000000000000100,
        ST_PLACE_WR = 15'b000000000001000,
        ST_ERASE_RD = 15'b000000000010000,
        ST_ERASE_WR = 15'b000000000100000,
        ST_READ_RD  = 15'b000000001000000,
        ST_READ_CAP = 15'b000000010000000,
        ST_TICK_RD  = 15'b000000100000000,
        ST_TICK_CHK = 15'b000001000000000,
        ST_NB_RD    = 15'b000010000000000,
        ST_NB_CHK   = 15'b000100000000000,
        ST_MOVE_DST = 15'b001000000000000,
        ST_MOVE_SRC = 15'b010000000000000,
        ST_RESP     = 15'b100000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    dir_t                dir_reg, dir_next;
    logic [COL_W-1:0]    x_reg, x_next;
    logic [ROW_W-1:0]    y_reg, y_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    cell_t               cur_reg, cur_next;
    result_t             res_reg, res_next;

    logic [31:0]         x_ext;
    logic [31:0]         y_ext;
    logic [31:0]         color_ext;
    logic                in_grid;
    logic                last_cell;
    state_t              adv_state;
    logic [COL_W-1:0]    x_adv;
    logic [ROW_W-1:0]    y_adv;

    assign x_ext     = 32'(item.x);
    assign y_ext     = 32'(item.y);
    assign color_ext = 32'(item.color);
    assign in_grid   = (x_ext < 32'(GRID_COLS)) && (y_ext < 32'(GRID_ROWS));
    assign last_cell = (x_reg == '0) && (y_reg == '0);

    always_comb
    begin
        adv_state = ST_TICK_RD;
        x_adv     = x_reg;
        y_adv     = y_reg - ROW_W'(1);
        if (last_cell)
        begin
            adv_state = ST_RESP;
        end
        else if (y_reg == '0)
        begin
            x_adv = x_reg - COL_W'(1);
            y_adv = ROW_LAST;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        dir_next   = dir_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        color_next = color_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = unit_addr;
        wr_data    = cur_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next   = '0;
                    dir_next   = DIR_SELF;
                    x_next     = x_ext[COL_W-1:0];
                    y_next     = y_ext[ROW_W-1:0];
                    color_next = (color_ext > 32'(NUM_COLORS - 1)) ? COLOR_TOP : item.color;
                    unique case (item.op)
                        OP_PLACE: state_next = in_grid ? ST_PLACE_RD : ST_RESP;
                        OP_ERASE: state_next = in_grid ? ST_ERASE_RD : ST_RESP;
                        OP_READ:  state_next = in_grid ? ST_READ_RD : ST_RESP;
                        OP_TICK:
                        begin
                            x_next     = COL_LAST;
                            y_next     = ROW_LAST;
                            state_next = ST_TICK_RD;
                        end
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_PLACE_RD:
            begin
                state_next = ST_PLACE_WR;
            end
            ST_PLACE_WR:
            begin
                if (!rd_data.occ)
                begin
                    wr_en              = 1'b1;
                    wr_data.occ        = 1'b1;
                    wr_data.color      = color_reg;
                    res_next.placed_ok = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_ERASE_RD:
            begin
                state_next = unit_valid ? ST_ERASE_WR : ST_RESP;
            end
            ST_ERASE_WR:
            begin
                wr_en         = 1'b1;
                wr_data.occ   = 1'b0;
                wr_data.color = rd_data.color;
                if (dir_reg == DIR_SELF)
                begin
                    dir_next   = DIR_EAST;
                    state_next = ST_ERASE_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_READ_RD:
            begin
                state_next = ST_READ_CAP;
            end
            ST_READ_CAP:
            begin
                res_next.cell_occupied = rd_data.occ;
                res_next.cell_color    = rd_data.color;
                state_next             = ST_RESP;
            end
            ST_TICK_RD:
            begin
                state_next = ST_TICK_CHK;
            end
            ST_TICK_CHK:
            begin
                cur_next = rd_data;
                if (rd_data.occ && (y_reg != ROW_LAST))
                begin
                    dir_next   = DIR_DOWN;
                    state_next = ST_NB_RD;
                end
                else
                begin
                    x_next     = x_adv;
                    y_next     = y_adv;
                    state_next = adv_state;
                end
            end
            ST_NB_RD:
            begin
                if (unit_valid)
                begin
                    state_next = ST_NB_CHK;
                end
                else if (dir_reg == DIR_RIGHT)
                begin
                    dir_next   = DIR_SELF;
                    x_next     = x_adv;
                    y_next     = y_adv;
                    state_next = adv_state;
                end
                else
                begin
                    dir_next = (dir_reg == DIR_DOWN) ? DIR_LEFT : DIR_RIGHT;
                end
            end
            ST_NB_CHK:
            begin
                if (!rd_data.occ)
                begin
                    state_next = ST_MOVE_DST;
                end
                else if (dir_reg == DIR_RIGHT)
                begin
                    dir_next   = DIR_SELF;
                    x_next     = x_adv;
                    y_next     = y_adv;
                    state_next = adv_state;
                end
                else
                begin
                    dir_next   = (dir_reg == DIR_DOWN) ? DIR_LEFT : DIR_RIGHT;
                    state_next = ST_NB_RD;
                end
            end
            ST_MOVE_DST:
            begin
                wr_en      = 1'b1;
                wr_data    = cur_reg;
                dir_next   = DIR_SELF;
                state_next = ST_MOVE_SRC;
            end
            ST_MOVE_SRC:
            begin
                wr_en         = 1'b1;
                wr_data.occ   = 1'b0;
                wr_data.color = cur_reg.color;
                x_next        = x_adv;
                y_next        = y_adv;
                state_next    = adv_state;
            end
            ST_RESP:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            dir_reg   <= DIR_SELF;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            dir_reg   <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        color_reg <= color_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;
    assign unit_x    = x_reg;
    assign unit_y    = y_reg;
    assign unit_dir  = dir_reg;
    assign rd_addr   = unit_addr;

endmodule

// ----- design/falling_sand_grid_step.sv -----
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Falling-sand grid: place, erase, read and in-place tick sweep of a cell store.
//
//   channel  dir  signals                      content
//   s_axis   in   tvalid tready tdata tuser    one operation word
//   m_axis   out  tvalid tready tdata          one result word per operation
//
// Place, read and erase each read the target cell first; erase then clears it and
// its east neighbor. A tick visits every cell through the cell store; a grain not
// on the floor tries the cell below, then below-left, then below-right, and moves
// to the first empty one. After reset a clearing pass writes GRID_COLS *
// 2**clog2(GRID_ROWS) entries before the first word is taken. A result waits in
// the sequencer until the output register can take it; the next word is taken then.
// ----------------------------------------------------------------------------
module falling_sand_grid_step
    import fsg_pkg::*;
#(
    parameter int GRID_COLS  = FSG_GRID_COLS,
    parameter int GRID_ROWS  = FSG_GRID_ROWS,
    parameter int NUM_COLORS = FSG_NUM_COLORS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // x_pos, y_pos, grain_color
    input  logic [OP_W-1:0]      s_axis_tuser,  // operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // placed_ok, cell_occupied, cell_color
);

    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;

    item_t              item;
    logic               start;
    logic               seq_ready;
    logic               res_valid;
    logic               res_take;
    result_t            res;
    logic [COL_W-1:0]   unit_x;
    logic [ROW_W-1:0]   unit_y;
    dir_t               unit_dir;
    logic [ADDR_W-1:0]  unit_addr;
    logic               unit_valid;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    cell_t              wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    cell_t              rd_data;
    logic               m_valid_reg;
    result_t            m_data_reg;

    assign item.op    = op_t'(s_axis_tuser);
    assign item.x     = s_axis_tdata[POS_W-1:0];
    assign item.y     = s_axis_tdata[2*POS_W-1:POS_W];
    assign item.color = s_axis_tdata[2*POS_W+COLOR_W-1:2*POS_W];

    assign s_axis_tready = seq_ready;
    assign start         = s_axis_tvalid && seq_ready;
    assign res_take      = res_valid && (!m_valid_reg || m_axis_tready);

    fsg_seq #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .NUM_COLORS (NUM_COLORS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .ready      (seq_ready),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .unit_x     (unit_x),
        .unit_y     (unit_y),
        .unit_dir   (unit_dir),
        .unit_addr  (unit_addr),
        .unit_valid (unit_valid),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    fsg_addr_unit #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_addr_unit (
        .x     (unit_x),
        .y     (unit_y),
        .dir   (unit_dir),
        .addr  (unit_addr),
        .valid (unit_valid)
    );

    fsg_cell_mem #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_cell_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - 2 - COLOR_W)'(0), m_data_reg.cell_color,
                            m_data_reg.cell_occupied, m_data_reg.placed_ok};

endmodule
